// File: design/ptb_pkg.sv
// Shared types, constants and helpers for the periodic timer bank.
package ptb_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
  localparam int PERIOD_W    = 32;
  localparam int KIND_W      = 2;
  localparam int OUT_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ATTACHED = 2'd0,
    KIND_FIRED    = 2'd1,
    KIND_QUIET    = 2'd2,
    KIND_FULL     = 2'd3
  } kind_t;

  typedef struct packed {
    logic                attach;
    logic [PERIOD_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [OUT_IDX_W-1:0] idx_to_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, idx};
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

// File: design/ptb_front.sv
// Front end: takes in commands, classifies them and pushes requests to the queue.
module ptb_front (
  input  logic                       start,
  input  logic                       in_mode,
  input  logic [ptb_pkg::PERIOD_W-1:0] in_period,
  input  ptb_pkg::q_status_t         q_status,
  output logic                       busy,
  output logic                       push,
  output ptb_pkg::req_t              push_req
);
  import ptb_pkg::*;

  always_comb begin
    busy            = q_status.full;
    push            = start && !q_status.full;
    push_req.attach = in_mode;
    push_req.period = in_mode ? in_period : '0;
  end

endmodule

// File: design/ptb_queue.sv
// Short request queue between the front end and the timer engine.
module ptb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ptb_pkg::req_t      push_req,
  input  logic               pop,
  output ptb_pkg::req_t      pop_req,
  output ptb_pkg::q_status_t status
);
  import ptb_pkg::*;

  req_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign do_push      = push && (count_r != QCNT_W'(QUEUE_DEPTH));
  assign do_pop       = pop && (count_r != '0);
  assign pop_req      = entry_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        entry_r[wr_ptr_r] <= push_req;
        wr_ptr_r          <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: design/ptb_back.sv
// Timer engine: holds the timer table, attaches timers and sweeps them on each tick.
module ptb_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ptb_pkg::q_status_t         q_status,
  input  ptb_pkg::req_t              req,
  output logic                       pop,
  output logic                       out_valid,
  output logic [ptb_pkg::KIND_W-1:0] out_kind,
  output logic [ptb_pkg::OUT_IDX_W-1:0] out_timer_index,
  output logic                       out_last
);
  import ptb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       timer_count_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   pend_valid_r;
  logic [IDX_W-1:0]       pend_idx_r;
  logic [PERIOD_W-1:0]    reload_period_r [NUM_TIMERS];
  logic [PERIOD_W-1:0]    ticks_left_r    [NUM_TIMERS];
  logic                   out_valid_r;
  kind_t                  out_kind_r;
  logic [OUT_IDX_W-1:0]   out_idx_r;
  logic                   out_last_r;

  logic [PERIOD_W-1:0]    cur_period;
  logic [PERIOD_W-1:0]    cur_dec;
  logic                   cur_fire;
  logic [CNT_W-1:0]       count_m1;
  logic                   table_full;

  assign cur_period = reload_period_r[idx_r];
  assign cur_dec    = ticks_left_r[idx_r] - 1'b1;
  assign cur_fire   = (cur_period == '0) || (cur_dec == '0);
  assign count_m1   = timer_count_r - 1'b1;
  assign table_full = (timer_count_r == CNT_W'(NUM_TIMERS));
  assign pop        = (state_r == ST_IDLE) && !q_status.empty;

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_timer_index = out_idx_r;
  assign out_last        = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      timer_count_r <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!q_status.empty) begin
            if (req.attach) begin
              out_valid_r <= 1'b1;
              out_last_r  <= 1'b1;
              if (table_full) begin
                out_kind_r <= KIND_FULL;
                out_idx_r  <= '0;
              end else begin
                reload_period_r[timer_count_r[IDX_W-1:0]] <= req.period;
                ticks_left_r[timer_count_r[IDX_W-1:0]]    <= req.period;
                out_kind_r    <= KIND_ATTACHED;
                out_idx_r     <= idx_to_out(timer_count_r[IDX_W-1:0]);
                timer_count_r <= timer_count_r + 1'b1;
              end
            end else if (timer_count_r == '0) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= KIND_QUIET;
              out_idx_r   <= '0;
              out_last_r  <= 1'b1;
            end else begin
              idx_r        <= count_m1[IDX_W-1:0];
              pend_valid_r <= 1'b0;
              state_r      <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (cur_period != '0) begin
            ticks_left_r[idx_r] <= (cur_dec == '0) ? cur_period : cur_dec;
          end
          if (cur_fire) begin
            if (pend_valid_r) begin
              out_valid_r <= 1'b1;
              out_kind_r  <= KIND_FIRED;
              out_idx_r   <= idx_to_out(pend_idx_r);
              out_last_r  <= 1'b0;
            end
            pend_valid_r <= 1'b1;
            pend_idx_r   <= idx_r;
          end
          if (idx_r == '0) begin
            state_r <= ST_FINISH;
          end else begin
            idx_r <= idx_r - 1'b1;
          end
        end
        ST_FINISH: begin
          out_valid_r <= 1'b1;
          out_last_r  <= 1'b1;
          if (pend_valid_r) begin
            out_kind_r <= KIND_FIRED;
            out_idx_r  <= idx_to_out(pend_idx_r);
          end else begin
            out_kind_r <= KIND_QUIET;
            out_idx_r  <= '0;
          end
          pend_valid_r <= 1'b0;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: design/periodic_timer_bank.sv
// Top level of the periodic timer bank: front end, request queue and timer engine.
// With the queue empty, an attach or a tick on an empty table passes through the queue entry and
// is answered from the engine's output register; a tick holds each firing pending in the sweep
// and gives it out at the next firing or in the finish state. The engine pops only while idle,
// so a tick with timers holds it through sweep and finish; a two-entry queue takes requests ahead.
// The receiver cannot stall. Synchronous reset clears the timer count, queue and engine.
module periodic_timer_bank_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [ptb_pkg::PERIOD_W-1:0]  in_period,
  output logic                          out_valid,
  output logic [ptb_pkg::KIND_W-1:0]    out_kind,
  output logic [ptb_pkg::OUT_IDX_W-1:0] out_timer_index,
  output logic                          out_last
);
  import ptb_pkg::*;

  q_status_t q_status;
  logic      push;
  req_t      push_req;
  logic      pop;
  req_t      pop_req;

  ptb_front u_front (
    .start    (start),
    .in_mode  (in_mode),
    .in_period(in_period),
    .q_status (q_status),
    .busy     (busy),
    .push     (push),
    .push_req (push_req)
  );

  ptb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_req(push_req),
    .pop     (pop),
    .pop_req (pop_req),
    .status  (q_status)
  );

  ptb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .req            (pop_req),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_timer_index(out_timer_index),
    .out_last       (out_last)
  );

endmodule
